>>> rtl/tmbl_pkg.sv
// Shared constants and types for the trimmed-mean battery level block.
// No dependencies.
package tmbl_pkg;

   localparam int SAMPLE_BITS       = 12;
   localparam int SAMPLES_PER_BURST = 10;
   localparam int BURSTS_PER_RESULT = 4;

   localparam int COUNT_W  = $clog2(SAMPLES_PER_BURST);
   localparam int BURST_W  = $clog2(BURSTS_PER_RESULT);
   localparam int TOTAL_W  = SAMPLE_BITS + $clog2(SAMPLES_PER_BURST);
   localparam int MEANS_W  = SAMPLE_BITS + BURST_W;
   localparam int PCT_W    = 7;
   localparam int QUOT_W   = PCT_W;
   localparam int NUM_W    = SAMPLE_BITS + QUOT_W;
   localparam int DCNT_W   = $clog2(QUOT_W + 1);
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
   localparam logic [PCT_W-1:0] PCT_ZERO = '0;

   // register indexes (paddr[2])
   localparam logic REG_EMPTY = 1'b0;
   localparam logic REG_FULL  = 1'b1;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } tmbl_div_sts_type;

endpackage

>>> rtl/tmbl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tmbl_pkg. Quotient must fit in QUOT_W bits.
module tmbl_div
   import tmbl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_W-1:0]       numerator,
   input  logic [SAMPLE_BITS-1:0] divisor,
   output logic [QUOT_W-1:0]      quotient,
   output tmbl_div_sts_type       sts
);

   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]      num_lo_ff, num_lo_in;
   logic [SAMPLE_BITS-1:0] den_ff, den_in;
   logic [QUOT_W-1:0]      quot_ff, quot_in;
   logic [DCNT_W-1:0]      cnt_ff, cnt_in;
   logic                   done_ff, done_in;

   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   diff;
   logic                   fits;

   always_comb begin
      trial = {rem_ff, num_lo_ff[QUOT_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      rem_in    = rem_ff;
      num_lo_in = num_lo_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;

      if (start) begin
         // top bits are already below the divisor since quotient < 2**QUOT_W
         rem_in    = numerator[NUM_W-1:QUOT_W];
         num_lo_in = numerator[QUOT_W-1:0];
         den_in    = divisor;
         quot_in   = '0;
         cnt_in    = DCNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         rem_in    = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         num_lo_in = {num_lo_ff[QUOT_W-2:0], 1'b0};
         quot_in   = {quot_ff[QUOT_W-2:0], fits};
         cnt_in    = cnt_ff - DCNT_W'(1);
         done_in   = (cnt_ff == DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      num_lo_ff <= num_lo_in;
      den_ff    <= den_in;
      quot_ff   <= quot_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quot_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;

endmodule

>>> rtl/trimmed_mean_battery_level.sv
// Trimmed-mean battery level top: trimming, averaging, percent scaling; uses tmbl_pkg, tmbl_div.
// Flow: each request is taken in idle; the 10th of a burst then adds a trim step; the 40th adds trim,
// scale, the divider (one step per quotient bit, then done) and an output load before rsp_valid rises.
// Throughput: 40 requests per result; input stalled during trim, scale, divide and output load
// (no divide when the level clamps) plus any result hold-off, mostly the divider.
// Reset (synchronous): burst/average state cleared, empty_level 0, full_level 4095.
module trimmed_mean_battery_level
   import tmbl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PCT_W-1:0]       rsp_level_percent,
   output logic [SAMPLE_BITS-1:0] rsp_average_raw,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // taking requests
   localparam logic [2:0] ST_TRIM  = 3'd1;  // burst closed, fold trimmed mean
   localparam logic [2:0] ST_SCALE = 3'd2;  // clamp or launch divide
   localparam logic [2:0] ST_DIV   = 3'd3;  // waiting on divider
   localparam logic [2:0] ST_POST  = 3'd4;  // hand result to output register

   logic [2:0]             state_ff, state_in;

   // config registers
   logic [SAMPLE_BITS-1:0] empty_ff, empty_in;
   logic [SAMPLE_BITS-1:0] full_ff, full_in;

   // burst accumulation
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [SAMPLE_BITS-1:0] largest_ff, largest_in;
   logic [SAMPLE_BITS-1:0] smallest_ff, smallest_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [BURST_W-1:0]     bursts_ff, bursts_in;
   logic [MEANS_W-1:0]     means_ff, means_in;

   // result path
   logic [SAMPLE_BITS-1:0] level_ff, level_in;
   logic [PCT_W-1:0]       pct_ff, pct_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]       rsp_pct_ff, rsp_pct_in;
   logic [SAMPLE_BITS-1:0] rsp_raw_ff, rsp_raw_in;

   // divider interface
   logic                   div_start;
   logic [NUM_W-1:0]       div_num;
   logic [SAMPLE_BITS-1:0] div_den;
   logic [QUOT_W-1:0]      div_quot;
   tmbl_div_sts_type       div_sts;

   logic                   accept;
   logic                   csr_wr;
   logic [TOTAL_W-1:0]     trimmed_wide;
   logic [MEANS_W-1:0]     means_sum;
   logic [SAMPLE_BITS-1:0] span;
   logic [NUM_W-1:0]       span_ext;
   logic                   load_out;

   assign accept = req_valid && !req_stall;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes; values already fit SAMPLE_BITS after the slice
   always_comb begin
      empty_in = empty_ff;
      full_in  = full_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_EMPTY: empty_in = csr_pwdata[SAMPLE_BITS-1:0];
            REG_FULL:  full_in  = csr_pwdata[SAMPLE_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_EMPTY: csr_prdata = CSR_DW'(empty_ff);
         REG_FULL:  csr_prdata = CSR_DW'(full_ff);
         default:   csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // trimmed mean: total minus one largest and one smallest, divided by 8
   assign trimmed_wide = (total_ff - TOTAL_W'(largest_ff) - TOTAL_W'(smallest_ff)) >> 3;
   assign means_sum    = means_ff + trimmed_wide[MEANS_W-1:0];

   // (level - empty) * 100 as shift-add: 64 + 32 + 4
   assign span     = level_ff - empty_ff;
   assign span_ext = NUM_W'(span);
   assign div_num  = (span_ext << 6) + (span_ext << 5) + (span_ext << 2);
   assign div_den  = full_ff - empty_ff;

   // output register frees when taken, so the next burst can start meanwhile
   assign load_out = (state_ff == ST_POST) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      largest_in  = largest_ff;
      smallest_in = smallest_ff;
      count_in    = count_ff;
      bursts_in   = bursts_ff;
      means_in    = means_ff;
      level_in    = level_ff;
      pct_in      = pct_ff;
      div_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               total_in    = total_ff + TOTAL_W'(req_sample);
               largest_in  = (req_sample > largest_ff)  ? req_sample : largest_ff;
               smallest_in = (req_sample < smallest_ff) ? req_sample : smallest_ff;
               count_in    = count_ff + COUNT_W'(1);
               if (count_ff == COUNT_W'(SAMPLES_PER_BURST - 1)) begin
                  state_in = ST_TRIM;
               end
            end
         end
         ST_TRIM: begin
            total_in    = '0;
            largest_in  = '0;
            smallest_in = '1;
            count_in    = '0;
            bursts_in   = bursts_ff + BURST_W'(1);
            if (bursts_ff == BURST_W'(BURSTS_PER_RESULT - 1)) begin
               level_in = means_sum[MEANS_W-1:BURST_W];
               means_in = '0;
               state_in = ST_SCALE;
            end else begin
               means_in = means_sum;
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            // full test first: covers empty >= full with no divide
            if (level_ff >= full_ff) begin
               pct_in   = PCT_FULL;
               state_in = ST_POST;
            end else if (level_ff <= empty_ff) begin
               pct_in   = PCT_ZERO;
               state_in = ST_POST;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               pct_in   = div_quot;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pct_in   = rsp_pct_ff;
      rsp_raw_in   = rsp_raw_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_pct_in   = pct_ff;
         rsp_raw_in   = level_ff;
      end
   end

   tmbl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (div_den),
      .quotient  (div_quot),
      .sts       (div_sts)
   );

   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      pct_ff     <= pct_in;
      rsp_pct_ff <= rsp_pct_in;
      rsp_raw_ff <= rsp_raw_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         empty_ff     <= '0;
         full_ff      <= '1;
         total_ff     <= '0;
         largest_ff   <= '0;
         smallest_ff  <= '1;
         count_ff     <= '0;
         bursts_ff    <= '0;
         means_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         empty_ff     <= empty_in;
         full_ff      <= full_in;
         total_ff     <= total_in;
         largest_ff   <= largest_in;
         smallest_ff  <= smallest_in;
         count_ff     <= count_in;
         bursts_ff    <= bursts_in;
         means_ff     <= means_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // requests only taken while the sequencer is idle
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_percent = rsp_pct_ff;
   assign rsp_average_raw   = rsp_raw_ff;

   // last request of a burst always leads to the trim step
   a_burst_close: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff == COUNT_W'(SAMPLES_PER_BURST - 1)) |=> state_ff == ST_TRIM)
      else $error("burst close did not enter trim");

   // divider only runs under the divide state
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (div_sts.busy || div_sts.done) |-> state_ff == ST_DIV)
      else $error("divider active outside divide state");

   // percentage never exceeds full scale
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pct_ff <= PCT_FULL)
      else $error("percent out of range");

endmodule

>>> dv/trimmed_mean_battery_level_checker.sv
// Checker for the trimmed-mean battery level block. It mirrors the burst
// trimming, averaging and percent scaling, and compares every result.
// Depends on tmbl_pkg.
`timescale 1ns / 100ps

module trimmed_mean_battery_level_checker
   import tmbl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [PCT_W-1:0]       rsp_level_percent,
   input  logic [SAMPLE_BITS-1:0] rsp_average_raw,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   input  logic                   csr_pready,
   output int                     fail_count,
   output int                     pending,
   output int                     levels_checked
);

   localparam int PERCENT_SPAN  = 100;
   localparam int TRIM_SHIFT    = 3;
   localparam int AVERAGE_SHIFT = 2;
   localparam logic [SAMPLE_BITS-1:0] RAW_MAX = '1;

   typedef struct packed {
      logic [PCT_W-1:0]       percent;
      logic [SAMPLE_BITS-1:0] raw;
   } charge_reading_type;

   charge_reading_type     expected_readings[$];
   charge_reading_type     oldest;

   logic [SAMPLE_BITS-1:0] empty_lvl;
   logic [SAMPLE_BITS-1:0] full_lvl;
   logic [TOTAL_W-1:0]     burst_sum;
   logic [SAMPLE_BITS-1:0] burst_max;
   logic [SAMPLE_BITS-1:0] burst_min;
   logic [MEANS_W-1:0]     means_sum;
   int                     taken;
   int                     bursts;
   int                     errors  = 0;
   int                     checked = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns: level check: %s", $time, msg);
   endtask

   task automatic restart_burst();
      burst_sum = '0;
      burst_max = '0;
      burst_min = RAW_MAX;
      taken     = 0;
   endtask

   // Full test first, so a crossed or equal pair never reaches the divide.
   function automatic logic [PCT_W-1:0] charge_percent(input logic [SAMPLE_BITS-1:0] level);
      if (level >= full_lvl)
         return PCT_FULL;
      if (level <= empty_lvl)
         return PCT_ZERO;
      return PCT_W'(((int'(level) - int'(empty_lvl)) * PERCENT_SPAN)
                    / (int'(full_lvl) - int'(empty_lvl)));
   endfunction

   task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] trimmed;
      charge_reading_type     r;
      burst_sum = burst_sum + s;
      if (s > burst_max)
         burst_max = s;
      if (s < burst_min)
         burst_min = s;
      taken++;
      if (taken < SAMPLES_PER_BURST)
         return;
      trimmed = SAMPLE_BITS'((burst_sum - burst_max - burst_min) >> TRIM_SHIFT);
      restart_burst();
      means_sum = means_sum + trimmed;
      bursts++;
      if (bursts < BURSTS_PER_RESULT)
         return;
      r.raw     = SAMPLE_BITS'(means_sum >> AVERAGE_SHIFT);
      r.percent = charge_percent(r.raw);
      means_sum = '0;
      bursts    = 0;
      expected_readings.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         empty_lvl = '0;
         full_lvl  = RAW_MAX;
         restart_burst();
         means_sum = '0;
         bursts    = 0;
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("result with none expected (%0d%%, raw %0d)",
                                         rsp_level_percent, rsp_average_raw));
            end else begin
               oldest = expected_readings.pop_front();
               checked++;
               if (rsp_level_percent !== oldest.percent)
                  report_mismatch($sformatf("level_percent got %0d, expected %0d",
                                            rsp_level_percent, oldest.percent));
               if (rsp_average_raw !== oldest.raw)
                  report_mismatch($sformatf("average_raw got %0d, expected %0d",
                                            rsp_average_raw, oldest.raw));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_paddr[2] == REG_EMPTY)
               empty_lvl = csr_pwdata[SAMPLE_BITS-1:0];
            else
               full_lvl = csr_pwdata[SAMPLE_BITS-1:0];
         end
         if (req_valid && !req_stall)
            absorb_sample(req_sample);
      end
      fail_count     <= errors;
      pending        <= expected_readings.size();
      levels_checked <= checked;
   end

endmodule

>>> dv/trimmed_mean_battery_level_test.sv
// Top of the trimmed-mean battery level testbench: clock, reset, sample and
// threshold stimulus, receiver stalls and verdict. Depends on tmbl_pkg, the
// block and trimmed_mean_battery_level_checker.
`timescale 1ns / 100ps

module trimmed_mean_battery_level_test;
   import tmbl_pkg::*;

   localparam int MAX_RAW            = (1 << SAMPLE_BITS) - 1;
   localparam int SAMPLES_PER_RESULT = SAMPLES_PER_BURST * BURSTS_PER_RESULT;
   localparam int PHASES             = 8;
   localparam int ITEMS_PER_PHASE    = 240;
   localparam int HOLD_PHASE         = 2;     // receiver backs off for a long stretch
   localparam int QUIET_PHASE        = 6;     // neither side idles
   localparam int HOLD_CYCLES        = 800;
   localparam int DRAIN_CYCLES       = 24;    // time to result plus divider busy time
   localparam int WATCHDOG_LIMIT     = 4000;

   // how the samples of one 40-request group are shaped
   typedef enum int {
      SHAPE_FLAT,    // every sample equal: level lands exactly on the base
      SHAPE_NEAR,    // base plus small noise
      SHAPE_WIDE,    // uniform over the full converter range
      SHAPE_SPIKE    // base with scattered rail-to-rail outliers
   } group_shape_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PCT_W-1:0]       rsp_level_percent;
   logic [SAMPLE_BITS-1:0] rsp_average_raw;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int pending;
   int levels_checked;

   int samples_sent    = 0;
   int quiet_cycles    = 0;
   int pushback_cycles = 0;
   int cur_empty       = 0;
   int cur_full        = MAX_RAW;
   bit no_idle         = 1'b0;
   bit hold_now        = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   trimmed_mean_battery_level dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_level_percent (rsp_level_percent),
      .rsp_average_raw   (rsp_average_raw),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   trimmed_mean_battery_level_checker level_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_level_percent (rsp_level_percent),
      .rsp_average_raw   (rsp_average_raw),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending           (pending),
      .levels_checked    (levels_checked)
   );

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_raw(input int v);
      if (v < 0)
         return 0;
      if (v > MAX_RAW)
         return MAX_RAW;
      return v;
   endfunction

   // One request: optional gap with valid low, then hold until accepted.
   // Valid stays high on return so back-to-back requests need no extra edge.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // APB setup + access. psel is left high so a second write can follow
   // directly with a fresh setup; the caller drops psel after the last one.
   // Upper data bits are random: the register keeps only the low 12.
   task automatic write_reg(input logic reg_index, input int value);
      logic [CSR_DW-1:0] word;
      word = $urandom();
      word[SAMPLE_BITS-1:0] = value[SAMPLE_BITS-1:0];
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({reg_index, 2'b00});
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Stop offering, let every predicted result arrive, then give a
   // partially filled burst time to settle before touching the registers.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Activity watch: any accepted request or result resets the idle count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (req_valid && req_stall)
         pushback_cycles <= pushback_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("trimmed_mean_battery_level_test: FAIL");
      $finish;
   end

   // Receiver: alternating stall and ready runs of random length; a single
   // long hold-off when asked, so the block fills and stalls its input.
   initial begin : result_stalls
      bit stalling;
      stalling = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_now) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_now = 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            stalling = !stalling;
            rsp_stall <= stalling;
            repeat (1 + idle_len()) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int              phase;
      int              i;
      int              sample_val;
      int              base;
      int              spread;
      group_shape_type shape;

      shape  = SHAPE_FLAT;
      base   = MAX_RAW / 2;
      spread = 1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: begin        // empty above full: everything is 0 or 100
                  cur_empty = MAX_RAW;
                  cur_full  = 1;
               end
               2: begin        // empty equal to full
                  cur_empty = MAX_RAW / 2 + 1;
                  cur_full  = MAX_RAW / 2 + 1;
               end
               3: begin        // narrowest window at the bottom
                  cur_empty = 0;
                  cur_full  = 1;
               end
               4: begin        // narrowest window at the top
                  cur_empty = MAX_RAW - 1;
                  cur_full  = MAX_RAW;
               end
               5: begin        // ordinary window
                  cur_empty = $urandom_range(0, MAX_RAW - 1);
                  cur_full  = $urandom_range(cur_empty + 1, MAX_RAW);
               end
               6: begin        // any pair, crossed or not
                  cur_empty = $urandom_range(0, MAX_RAW);
                  cur_full  = $urandom_range(0, MAX_RAW);
               end
               default: begin  // back to the reset values, written explicitly
                  cur_empty = 0;
                  cur_full  = MAX_RAW;
               end
            endcase
            write_reg(REG_EMPTY, cur_empty);
            write_reg(REG_FULL, cur_full);
            csr_psel    <= 1'b0;
            csr_penable <= 1'b0;
            csr_pwrite  <= 1'b0;
         end else begin
            // Directed: a burst pinned at full scale, then a burst of rail
            // and checkerboard values where trimming drops one sample at each rail.
            for (i = 0; i < SAMPLES_PER_BURST; i++)
               send_sample(SAMPLE_BITS'(MAX_RAW));
            for (i = 0; i < SAMPLES_PER_BURST; i++) begin
               case (i % 4)
                  0:       sample_val = 0;
                  1:       sample_val = MAX_RAW;
                  2:       sample_val = 'h555;
                  default: sample_val = 'hAAA;
               endcase
               send_sample(SAMPLE_BITS'(sample_val));
            end
         end

         no_idle = (phase == QUIET_PHASE);
         if (phase == HOLD_PHASE)
            hold_now = 1'b1;

         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // New shape and base at each result boundary. Bases favor the
            // thresholds and their neighbors so both clamps and the first
            // steps of the linear region are hit.
            if (samples_sent % SAMPLES_PER_RESULT == 0) begin
               shape = group_shape_type'($urandom_range(0, 3));
               case ($urandom_range(0, 7))
                  0:       base = cur_empty;
                  1:       base = cur_full;
                  2:       base = clamp_raw(cur_empty + int'($urandom_range(0, 2)) - 1);
                  3:       base = clamp_raw(cur_full + int'($urandom_range(0, 2)) - 1);
                  4:       base = 0;
                  5:       base = MAX_RAW;
                  default: base = $urandom_range(0, MAX_RAW);
               endcase
               spread = $urandom_range(1, 64);
            end
            case (shape)
               SHAPE_FLAT: sample_val = base;
               SHAPE_NEAR: sample_val = clamp_raw(base + int'($urandom_range(0, 2 * spread))
                                                  - spread);
               SHAPE_WIDE: sample_val = $urandom_range(0, MAX_RAW);
               default: begin
                  if ($urandom_range(0, 4) == 0)
                     sample_val = $urandom_range(0, 1) ? MAX_RAW : 0;
                  else
                     sample_val = base;
               end
            endcase
            send_sample(SAMPLE_BITS'(sample_val));
         end
      end

      wait_drained();
      $display("covered %0d samples under %0d threshold settings, %0d charge readings compared",
               samples_sent, PHASES, levels_checked);
      $display("input pushed back for %0d cycles, including one %0d-cycle result hold-off",
               pushback_cycles, HOLD_CYCLES);
      if (fail_count == 0 && pending == 0)
         $display("trimmed_mean_battery_level_test: PASS");
      else
         $display("trimmed_mean_battery_level_test: FAIL");
      $finish;
   end

endmodule
